FILE: rtl/mth_pkg.sv
package mth_pkg;

   // Transfer modes
   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_UPLOAD   = 2'd1,
      MODE_DOWNLOAD = 2'd2,
      MODE_CLEAR    = 2'd3
   } mode_type;

   // Input actions
   localparam logic [2:0] ACT_TICK           = 3'd0;
   localparam logic [2:0] ACT_START_UPLOAD   = 3'd1;
   localparam logic [2:0] ACT_START_DOWNLOAD = 3'd2;
   localparam logic [2:0] ACT_START_CLEAR    = 3'd3;
   localparam logic [2:0] ACT_REQUEST        = 3'd4;
   localparam logic [2:0] ACT_COUNT          = 3'd5;
   localparam logic [2:0] ACT_ITEM           = 3'd6;
   localparam logic [2:0] ACT_ACK            = 3'd7;

   // Message kinds to send
   localparam logic [2:0] SEND_NONE    = 3'd0;
   localparam logic [2:0] SEND_COUNT   = 3'd1;
   localparam logic [2:0] SEND_ITEM    = 3'd2;
   localparam logic [2:0] SEND_REQUEST = 3'd3;
   localparam logic [2:0] SEND_ACK     = 3'd4;
   localparam logic [2:0] SEND_LIST    = 3'd5;
   localparam logic [2:0] SEND_CLEAR   = 3'd6;

   // Event codes
   localparam logic [3:0] EV_NONE        = 4'd0;
   localparam logic [3:0] EV_PROGRESS    = 4'd1;
   localparam logic [3:0] EV_UPLOAD_DONE = 4'd2;
   localparam logic [3:0] EV_DOWN_DONE   = 4'd3;
   localparam logic [3:0] EV_CLEARED     = 4'd4;
   localparam logic [3:0] EV_BUSY        = 4'd5;
   localparam logic [3:0] EV_NO_RESPONSE = 4'd6;
   localparam logic [3:0] EV_BAD_INDEX   = 4'd7;
   localparam logic [3:0] EV_REJECTED    = 4'd8;

   // Register indexes
   localparam logic CSR_MAX_ATTEMPTS  = 1'b0;
   localparam logic CSR_TIMEOUT_TICKS = 1'b1;

   localparam logic [3:0]  MAX_ATTEMPTS_RESET  = 4'd3;
   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

   // Result queue sizing: up to four results per transaction
   localparam int ResMax = 4;
   localparam int QDepth = 8;
   localparam int QIdxW  = 3;
   localparam int QCntW  = 4;
   localparam int RCntW  = 3;

   typedef struct packed {
      logic [2:0]         action;
      logic [15:0]        seq_number;
      logic [15:0]        item_count;
      logic [7:0]         ack_type;
      logic [15:0]        in_command;
      logic signed [31:0] in_latitude;
      logic signed [31:0] in_longitude;
      logic [31:0]        in_altitude;
   } req_type;

   typedef struct packed {
      logic [2:0]         send_kind;
      logic [15:0]        send_number;
      logic [3:0]         event_code;
      logic [15:0]        progress_done;
      logic [15:0]        progress_total;
      logic               item_valid;
      logic [15:0]        out_command;
      logic signed [31:0] out_latitude;
      logic signed [31:0] out_longitude;
      logic [31:0]        out_altitude;
      logic               last_result;
   } rsp_type;

   function automatic rsp_type mk_send(logic [2:0] kind, logic [15:0] number);
      rsp_type r;
      r = '0;
      r.send_kind = kind;
      r.send_number = number;
      return r;
   endfunction

   function automatic rsp_type mk_event(logic [3:0] code, logic [15:0] done,
                                        logic [15:0] total);
      rsp_type r;
      r = '0;
      r.event_code = code;
      r.progress_done = done;
      r.progress_total = total;
      return r;
   endfunction

endpackage

FILE: rtl/mission_transfer_handshake_unit.sv
// Mission transfer engine, ground side.
// Input channel (req_*): one transaction per start command, decoded peer
// message or timer tick. Result channel (rsp_*): one transaction per message
// to send, event or forwarded item; rsp_last_result marks the final result of
// an input transaction. Inputs that cause nothing produce no result.
// Configuration (csr_*): max_attempts at index 0, timeout_ticks at index 1,
// written by the user only while the engine is quiet; the block does not enforce it.
// Flow: an accepted transaction is held in the input register, its results
// are computed in a single pass and are registered into an 8-entry result
// queue, whose head drives the result port; the head result is taken at a
// clock edge where rsp_stall is low.
// Throughput: one input transaction per clock while each causes at most one
// result and the receiver does not stall; the result port delivers one result
// per clock while the receiver does not stall. The input register is
// processed only while the queue has room for four results.
// Reset clears mode, retry timer, totals, the queue and the input register and
// restores max_attempts to 3 and timeout_ticks to 1000.
// When the receiver stalls, the head result holds and the queue fills; once
// it cannot take four more, req_stall rises and the pending input holds.
module mission_transfer_handshake_unit (
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_write_en,
   input  logic                csr_index,
   input  logic [15:0]         csr_wdata,
   // input channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_action,
   input  logic [15:0]         req_seq_number,
   input  logic [15:0]         req_item_count,
   input  logic [7:0]          req_ack_type,
   input  logic [15:0]         req_in_command,
   input  logic signed [31:0]  req_in_latitude,
   input  logic signed [31:0]  req_in_longitude,
   input  logic [31:0]         req_in_altitude,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_send_kind,
   output logic [15:0]         rsp_send_number,
   output logic [3:0]          rsp_event_code,
   output logic [15:0]         rsp_progress_done,
   output logic [15:0]         rsp_progress_total,
   output logic                rsp_item_valid,
   output logic [15:0]         rsp_out_command,
   output logic signed [31:0]  rsp_out_latitude,
   output logic signed [31:0]  rsp_out_longitude,
   output logic [31:0]         rsp_out_altitude,
   output logic                rsp_last_result
);
   import mth_pkg::*;

   // configuration registers
   logic [3:0]  max_att_ff;
   logic [15:0] timeout_ff;

   // input register
   logic    in_valid_ff;
   req_type in_ff;

   // transfer state
   mode_type    mode_ff, mode_in;
   logic [3:0]  attempt_ff, attempt_in;
   logic [15:0] ticks_ff, ticks_in;
   logic        timer_ff, timer_in;
   logic [15:0] out_total_ff, out_total_in;
   logic [15:0] exp_total_ff, exp_total_in;
   logic [15:0] req_idx_ff, req_idx_in;
   logic [2:0]  saved_kind_ff, saved_kind_in;
   logic [15:0] saved_num_ff, saved_num_in;

   // result queue
   rsp_type           q_ff [QDepth];
   logic [QIdxW-1:0]  q_head_ff, q_tail_ff;
   logic [QCntW-1:0]  q_count_ff;

   // single-pass processing outputs
   rsp_type          res [ResMax];
   logic [RCntW-1:0] rcount;
   logic             space;
   logic             fire;
   logic             pop;
   logic             req_accept;

   assign space      = (q_count_ff <= QCntW'(ResMax));
   assign fire       = in_valid_ff && space;
   assign req_stall  = in_valid_ff && !space;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (q_count_ff != '0);
   assign pop        = rsp_valid && !rsp_stall;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_att_ff <= MAX_ATTEMPTS_RESET;
         timeout_ff <= TIMEOUT_TICKS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_MAX_ATTEMPTS:  max_att_ff <= csr_wdata[3:0];
            CSR_TIMEOUT_TICKS: timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // capture the input transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff.action       <= req_action;
         in_ff.seq_number   <= req_seq_number;
         in_ff.item_count   <= req_item_count;
         in_ff.ack_type     <= req_ack_type;
         in_ff.in_command   <= req_in_command;
         in_ff.in_latitude  <= req_in_latitude;
         in_ff.in_longitude <= req_in_longitude;
         in_ff.in_altitude  <= req_in_altitude;
      end
   end

   // compute results and next state for the held transaction
   always_comb begin
      logic        idle_go;
      logic        trk;
      logic [2:0]  trk_kind;
      logic [15:0] trk_num;
      logic [15:0] total_sat;
      logic [16:0] got;
      rsp_type     item_res;

      idle_go   = 1'b0;
      trk       = 1'b0;
      trk_kind  = SEND_NONE;
      trk_num   = '0;
      total_sat = (in_ff.item_count == 16'hFFFF) ? 16'hFFFF : in_ff.item_count + 16'd1;
      got       = {1'b0, req_idx_ff} + 17'd1;
      item_res  = '0;
      item_res.item_valid    = 1'b1;
      item_res.out_command   = in_ff.in_command;
      item_res.out_latitude  = in_ff.in_latitude;
      item_res.out_longitude = in_ff.in_longitude;
      item_res.out_altitude  = in_ff.in_altitude;

      mode_in      = mode_ff;
      attempt_in   = attempt_ff;
      ticks_in     = ticks_ff;
      timer_in     = timer_ff;
      out_total_in = out_total_ff;
      exp_total_in = exp_total_ff;
      req_idx_in   = req_idx_ff;
      saved_kind_in = saved_kind_ff;
      saved_num_in  = saved_num_ff;

      for (int k = 0; k < ResMax; k++) begin
         res[k] = '0;
      end
      rcount = '0;

      unique case (in_ff.action)
         ACT_TICK: begin
            if (timer_ff) begin
               if (ticks_ff > 16'd1) begin
                  ticks_in = ticks_ff - 16'd1;
               end else if (attempt_ff >= max_att_ff) begin
                  idle_go = 1'b1;
                  res[0]  = mk_event(EV_NO_RESPONSE, '0, '0);
                  rcount  = RCntW'(1);
               end else begin
                  attempt_in = attempt_ff + 4'd1;
                  ticks_in   = timeout_ff;
                  res[0]     = mk_send(saved_kind_ff, saved_num_ff);
                  rcount     = RCntW'(1);
               end
            end
         end
         ACT_START_UPLOAD, ACT_START_DOWNLOAD, ACT_START_CLEAR: begin
            if (mode_ff != MODE_IDLE) begin
               res[0] = mk_event(EV_BUSY, '0, '0);
               rcount = RCntW'(1);
            end else if (in_ff.action == ACT_START_UPLOAD && in_ff.item_count != '0) begin
               out_total_in = total_sat;
               mode_in      = MODE_UPLOAD;
               res[0]       = mk_event(EV_PROGRESS, '0, total_sat);
               trk          = 1'b1;
               trk_kind     = SEND_COUNT;
               trk_num      = total_sat;
               res[1]       = mk_send(SEND_COUNT, total_sat);
               rcount       = RCntW'(2);
            end else if (in_ff.action == ACT_START_DOWNLOAD) begin
               mode_in  = MODE_DOWNLOAD;
               trk      = 1'b1;
               trk_kind = SEND_LIST;
               res[0]   = mk_send(SEND_LIST, '0);
               rcount   = RCntW'(1);
            end else begin
               // clear, or upload of an empty plan
               mode_in  = MODE_CLEAR;
               trk      = 1'b1;
               trk_kind = SEND_CLEAR;
               res[0]   = mk_send(SEND_CLEAR, '0);
               rcount   = RCntW'(1);
            end
         end
         ACT_REQUEST: begin
            if (mode_ff == MODE_UPLOAD) begin
               if (in_ff.seq_number >= out_total_ff) begin
                  idle_go = 1'b1;
                  res[0]  = mk_event(EV_BAD_INDEX, '0, '0);
                  rcount  = RCntW'(1);
               end else begin
                  res[0]   = mk_event(EV_PROGRESS, in_ff.seq_number + 16'd1, out_total_ff);
                  trk      = 1'b1;
                  trk_kind = SEND_ITEM;
                  trk_num  = in_ff.seq_number;
                  res[1]   = mk_send(SEND_ITEM, in_ff.seq_number);
                  rcount   = RCntW'(2);
               end
            end
         end
         ACT_COUNT: begin
            if (mode_ff == MODE_DOWNLOAD) begin
               exp_total_in = in_ff.item_count;
               if (in_ff.item_count == '0) begin
                  idle_go = 1'b1;
                  res[0]  = mk_send(SEND_ACK, '0);
                  res[1]  = mk_event(EV_DOWN_DONE, '0, '0);
                  rcount  = RCntW'(2);
               end else begin
                  req_idx_in = '0;
                  res[0]     = mk_event(EV_PROGRESS, '0, in_ff.item_count);
                  trk        = 1'b1;
                  trk_kind   = SEND_REQUEST;
                  res[1]     = mk_send(SEND_REQUEST, '0);
                  rcount     = RCntW'(2);
               end
            end
         end
         ACT_ITEM: begin
            if (mode_ff == MODE_DOWNLOAD && in_ff.seq_number == req_idx_ff) begin
               // home item is consumed without forwarding
               if (in_ff.seq_number != '0) begin
                  res[0] = item_res;
                  res[1] = mk_event(EV_PROGRESS, got[15:0], exp_total_ff);
                  if (got >= {1'b0, exp_total_ff}) begin
                     idle_go = 1'b1;
                     res[2]  = mk_send(SEND_ACK, '0);
                     res[3]  = mk_event(EV_DOWN_DONE, '0, '0);
                     rcount  = RCntW'(4);
                  end else begin
                     req_idx_in = got[15:0];
                     trk        = 1'b1;
                     trk_kind   = SEND_REQUEST;
                     trk_num    = got[15:0];
                     res[2]     = mk_send(SEND_REQUEST, got[15:0]);
                     rcount     = RCntW'(3);
                  end
               end else begin
                  res[0] = mk_event(EV_PROGRESS, got[15:0], exp_total_ff);
                  if (got >= {1'b0, exp_total_ff}) begin
                     idle_go = 1'b1;
                     res[1]  = mk_send(SEND_ACK, '0);
                     res[2]  = mk_event(EV_DOWN_DONE, '0, '0);
                     rcount  = RCntW'(3);
                  end else begin
                     req_idx_in = got[15:0];
                     trk        = 1'b1;
                     trk_kind   = SEND_REQUEST;
                     trk_num    = got[15:0];
                     res[1]     = mk_send(SEND_REQUEST, got[15:0]);
                     rcount     = RCntW'(2);
                  end
               end
            end
         end
         ACT_ACK: begin
            if (mode_ff == MODE_UPLOAD || mode_ff == MODE_CLEAR) begin
               idle_go = 1'b1;
               if (in_ff.ack_type != '0) begin
                  res[0] = mk_event(EV_REJECTED, '0, '0);
                  rcount = RCntW'(1);
               end else if (mode_ff == MODE_UPLOAD) begin
                  res[0] = mk_event(EV_PROGRESS, out_total_ff, out_total_ff);
                  res[1] = mk_event(EV_UPLOAD_DONE, '0, '0);
                  rcount = RCntW'(2);
               end else begin
                  res[0] = mk_event(EV_CLEARED, '0, '0);
                  rcount = RCntW'(1);
               end
            end
         end
         default: ;
      endcase

      // arm retry tracking for the tracked send
      if (trk) begin
         saved_kind_in = trk_kind;
         saved_num_in  = trk_num;
         attempt_in    = 4'd1;
         ticks_in      = timeout_ff;
         timer_in      = 1'b1;
      end

      // drop back to idle; the requested index survives
      if (idle_go) begin
         mode_in       = MODE_IDLE;
         attempt_in    = '0;
         ticks_in      = '0;
         timer_in      = 1'b0;
         out_total_in  = '0;
         exp_total_in  = '0;
         saved_kind_in = SEND_NONE;
         saved_num_in  = '0;
      end

      // mark the final result
      for (int k = 0; k < ResMax; k++) begin
         if (RCntW'(k) + RCntW'(1) == rcount) begin
            res[k].last_result = 1'b1;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         attempt_ff    <= '0;
         ticks_ff      <= '0;
         timer_ff      <= 1'b0;
         out_total_ff  <= '0;
         exp_total_ff  <= '0;
         req_idx_ff    <= '0;
         saved_kind_ff <= SEND_NONE;
         saved_num_ff  <= '0;
      end else if (fire) begin
         mode_ff       <= mode_in;
         attempt_ff    <= attempt_in;
         ticks_ff      <= ticks_in;
         timer_ff      <= timer_in;
         out_total_ff  <= out_total_in;
         exp_total_ff  <= exp_total_in;
         req_idx_ff    <= req_idx_in;
         saved_kind_ff <= saved_kind_in;
         saved_num_ff  <= saved_num_in;
      end
   end

   // push results into the queue
   always_ff @(posedge clock) begin
      for (int k = 0; k < ResMax; k++) begin
         if (fire && (RCntW'(k) < rcount)) begin
            q_ff[q_tail_ff + QIdxW'(k)] <= res[k];
         end
      end
   end

   // advance queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         q_head_ff  <= '0;
         q_tail_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         if (fire) begin
            q_tail_ff <= q_tail_ff + QIdxW'(rcount);
         end
         if (pop) begin
            q_head_ff <= q_head_ff + QIdxW'(1);
         end
         q_count_ff <= q_count_ff + (fire ? QCntW'(rcount) : QCntW'(0))
                       - (pop ? QCntW'(1) : QCntW'(0));
      end
   end

   // present the head result
   assign rsp_send_kind      = q_ff[q_head_ff].send_kind;
   assign rsp_send_number    = q_ff[q_head_ff].send_number;
   assign rsp_event_code     = q_ff[q_head_ff].event_code;
   assign rsp_progress_done  = q_ff[q_head_ff].progress_done;
   assign rsp_progress_total = q_ff[q_head_ff].progress_total;
   assign rsp_item_valid     = q_ff[q_head_ff].item_valid;
   assign rsp_out_command    = q_ff[q_head_ff].out_command;
   assign rsp_out_latitude   = q_ff[q_head_ff].out_latitude;
   assign rsp_out_longitude  = q_ff[q_head_ff].out_longitude;
   assign rsp_out_altitude   = q_ff[q_head_ff].out_altitude;
   assign rsp_last_result    = q_ff[q_head_ff].last_result;

   // queue never overflows
   assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= QCntW'(QDepth))
      else $error("result queue overflow");

   // a processed transaction with results leaves the queue non-empty
   assert property (@(posedge clock) disable iff (reset)
      (fire && rcount != '0) |=> (q_count_ff != '0))
      else $error("results lost after processing");

   // the retry timer never runs while idle
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDLE) |-> !timer_ff)
      else $error("retry timer running in idle mode");

   // a running timer always has at least one send counted
   assert property (@(posedge clock) disable iff (reset)
      timer_ff |-> (attempt_ff != '0))
      else $error("timer running with zero attempts");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import mth_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 120;
   localparam int PRINT_LIMIT   = 50;

   typedef enum logic [1:0] {
      PACE_SLOW_SINK,
      PACE_SLOW_SOURCE,
      PACE_FREE
   } pace_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic        csr_index = CSR_MAX_ATTEMPTS;
   logic [15:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     offer = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_send_kind;
   logic [15:0] rsp_send_number;
   logic [3:0]  rsp_event_code;
   logic [15:0] rsp_progress_done;
   logic [15:0] rsp_progress_total;
   logic        rsp_item_valid;
   logic [15:0] rsp_out_command;
   logic signed [31:0] rsp_out_latitude;
   logic signed [31:0] rsp_out_longitude;
   logic [31:0] rsp_out_altitude;
   logic        rsp_last_result;

   pace_type pace = PACE_SLOW_SINK;

   // stimulus waiting to be offered, and results still owed by the block
   req_type pending_msgs[$];
   rsp_type pending_results[$];

   // shadow of the transfer engine
   logic [3:0]  cfg_max_attempts = MAX_ATTEMPTS_RESET;
   logic [15:0] cfg_timeout      = TIMEOUT_TICKS_RESET;
   mode_type    link_mode        = MODE_IDLE;
   logic [3:0]  attempts         = '0;
   logic [15:0] ticks_left       = '0;
   logic        timer_on         = 1'b0;
   logic [15:0] up_total         = '0;
   logic [15:0] down_total       = '0;
   logic [15:0] req_index        = '0;
   logic [2:0]  resend_kind      = '0;
   logic [15:0] resend_number    = '0;

   int mismatches = 0;
   int accepted_count = 0;
   int results_seen = 0;
   int queued_count = 0;
   int cycle_count = 0;
   int hold_left = 0;
   bit hold_used = 1'b0;
   int event_tally[0:15];

   mission_transfer_handshake_unit uut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (offer.action),
      .req_seq_number    (offer.seq_number),
      .req_item_count    (offer.item_count),
      .req_ack_type      (offer.ack_type),
      .req_in_command    (offer.in_command),
      .req_in_latitude   (offer.in_latitude),
      .req_in_longitude  (offer.in_longitude),
      .req_in_altitude   (offer.in_altitude),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_send_kind     (rsp_send_kind),
      .rsp_send_number   (rsp_send_number),
      .rsp_event_code    (rsp_event_code),
      .rsp_progress_done (rsp_progress_done),
      .rsp_progress_total(rsp_progress_total),
      .rsp_item_valid    (rsp_item_valid),
      .rsp_out_command   (rsp_out_command),
      .rsp_out_latitude  (rsp_out_latitude),
      .rsp_out_longitude (rsp_out_longitude),
      .rsp_out_altitude  (rsp_out_altitude),
      .rsp_last_result   (rsp_last_result)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   function automatic rsp_type outcome(logic [2:0] kind, logic [15:0] number,
                                       logic [3:0] code, logic [15:0] done,
                                       logic [15:0] total);
      rsp_type r;
      r = '0;
      r.send_kind      = kind;
      r.send_number    = number;
      r.event_code     = code;
      r.progress_done  = done;
      r.progress_total = total;
      return r;
   endfunction

   // remember a send for retry and start the timer
   function automatic rsp_type arm_retry(logic [2:0] kind, logic [15:0] number);
      resend_kind   = kind;
      resend_number = number;
      attempts      = 4'd1;
      ticks_left    = cfg_timeout;
      timer_on      = 1'b1;
      return outcome(kind, number, EV_NONE, '0, '0);
   endfunction

   // drop the transfer; the download index survives
   function automatic void abandon();
      link_mode     = MODE_IDLE;
      attempts      = '0;
      ticks_left    = '0;
      timer_on      = 1'b0;
      up_total      = '0;
      down_total    = '0;
      resend_kind   = '0;
      resend_number = '0;
   endfunction

   function automatic void predict_transfer(req_type t);
      rsp_type     batch[$];
      rsp_type     fwd;
      logic [16:0] sum;
      logic [15:0] total;
      case (t.action)
         ACT_TICK: begin
            if (timer_on) begin
               if (ticks_left > 16'd1) begin
                  ticks_left = ticks_left - 16'd1;
               end else if (attempts >= cfg_max_attempts) begin
                  abandon();
                  batch.push_back(outcome(SEND_NONE, '0, EV_NO_RESPONSE, '0, '0));
               end else begin
                  attempts   = attempts + 4'd1;
                  ticks_left = cfg_timeout;
                  batch.push_back(outcome(resend_kind, resend_number, EV_NONE, '0, '0));
               end
            end
         end
         ACT_START_UPLOAD, ACT_START_DOWNLOAD, ACT_START_CLEAR: begin
            if (link_mode != MODE_IDLE) begin
               batch.push_back(outcome(SEND_NONE, '0, EV_BUSY, '0, '0));
            end else if (t.action == ACT_START_UPLOAD && t.item_count != 16'd0) begin
               sum       = {1'b0, t.item_count} + 17'd1;
               up_total  = sum[16] ? 16'hFFFF : sum[15:0];
               link_mode = MODE_UPLOAD;
               batch.push_back(outcome(SEND_NONE, '0, EV_PROGRESS, '0, up_total));
               batch.push_back(arm_retry(SEND_COUNT, up_total));
            end else if (t.action == ACT_START_DOWNLOAD) begin
               link_mode = MODE_DOWNLOAD;
               batch.push_back(arm_retry(SEND_LIST, '0));
            end else begin
               // an empty upload plan behaves as a clear
               link_mode = MODE_CLEAR;
               batch.push_back(arm_retry(SEND_CLEAR, '0));
            end
         end
         ACT_REQUEST: begin
            if (link_mode == MODE_UPLOAD) begin
               if (t.seq_number >= up_total) begin
                  abandon();
                  batch.push_back(outcome(SEND_NONE, '0, EV_BAD_INDEX, '0, '0));
               end else begin
                  batch.push_back(outcome(SEND_NONE, '0, EV_PROGRESS,
                                          t.seq_number + 16'd1, up_total));
                  batch.push_back(arm_retry(SEND_ITEM, t.seq_number));
               end
            end
         end
         ACT_COUNT: begin
            if (link_mode == MODE_DOWNLOAD) begin
               down_total = t.item_count;
               if (t.item_count == 16'd0) begin
                  batch.push_back(outcome(SEND_ACK, '0, EV_NONE, '0, '0));
                  abandon();
                  batch.push_back(outcome(SEND_NONE, '0, EV_DOWN_DONE, '0, '0));
               end else begin
                  req_index = '0;
                  batch.push_back(outcome(SEND_NONE, '0, EV_PROGRESS, '0, down_total));
                  batch.push_back(arm_retry(SEND_REQUEST, '0));
               end
            end
         end
         ACT_ITEM: begin
            if (link_mode == MODE_DOWNLOAD && t.seq_number == req_index) begin
               // the home item is consumed but not forwarded
               if (t.seq_number != 16'd0) begin
                  fwd = outcome(SEND_NONE, '0, EV_NONE, '0, '0);
                  fwd.item_valid    = 1'b1;
                  fwd.out_command   = t.in_command;
                  fwd.out_latitude  = t.in_latitude;
                  fwd.out_longitude = t.in_longitude;
                  fwd.out_altitude  = t.in_altitude;
                  batch.push_back(fwd);
               end
               sum = {1'b0, req_index} + 17'd1;
               batch.push_back(outcome(SEND_NONE, '0, EV_PROGRESS, sum[15:0], down_total));
               if (sum >= {1'b0, down_total}) begin
                  batch.push_back(outcome(SEND_ACK, '0, EV_NONE, '0, '0));
                  abandon();
                  batch.push_back(outcome(SEND_NONE, '0, EV_DOWN_DONE, '0, '0));
               end else begin
                  req_index = sum[15:0];
                  batch.push_back(arm_retry(SEND_REQUEST, req_index));
               end
            end
         end
         default: begin
            if (link_mode == MODE_UPLOAD || link_mode == MODE_CLEAR) begin
               if (t.ack_type != 8'd0) begin
                  abandon();
                  batch.push_back(outcome(SEND_NONE, '0, EV_REJECTED, '0, '0));
               end else if (link_mode == MODE_UPLOAD) begin
                  total = up_total;
                  abandon();
                  batch.push_back(outcome(SEND_NONE, '0, EV_PROGRESS, total, total));
                  batch.push_back(outcome(SEND_NONE, '0, EV_UPLOAD_DONE, '0, '0));
               end else begin
                  abandon();
                  batch.push_back(outcome(SEND_NONE, '0, EV_CLEARED, '0, '0));
               end
            end
         end
      endcase
      if (batch.size() != 0) begin
         batch[batch.size() - 1].last_result = 1'b1;
      end
      foreach (batch[i]) pending_results.push_back(batch[i]);
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic bit chance(int n);
      return $urandom_range(n - 1, 0) == 0;
   endfunction

   function automatic logic [15:0] rnd16();
      return 16'($urandom);
   endfunction

   function automatic logic [7:0] rnd8();
      return 8'($urandom);
   endfunction

   function automatic req_type any_msg();
      req_type r;
      r.action       = 3'($urandom);
      r.seq_number   = rnd16();
      r.item_count   = rnd16();
      r.ack_type     = rnd8();
      r.in_command   = rnd16();
      r.in_latitude  = $urandom;
      r.in_longitude = $urandom;
      r.in_altitude  = $urandom;
      return r;
   endfunction

   task automatic add_msg(logic [2:0] act, logic [15:0] seq, logic [15:0] cnt,
                          logic [7:0] ack);
      req_type r;
      r            = any_msg();
      r.action     = act;
      r.seq_number = seq;
      r.item_count = cnt;
      r.ack_type   = ack;
      pending_msgs.push_back(r);
      queued_count++;
   endtask

   task automatic add_ticks();
      int n;
      n = chance(6) ? $urandom_range(8, 3) : $urandom_range(2, 0);
      repeat (n) add_msg(ACT_TICK, rnd16(), rnd16(), rnd8());
   endtask

   task automatic add_ack();
      add_msg(ACT_ACK, rnd16(), rnd16(), chance(5) ? 8'($urandom_range(255, 1)) : 8'd0);
   endtask

   task automatic maybe_busy();
      if (chance(12)) add_msg(3'($urandom_range(3, 1)), rnd16(), rnd16(), rnd8());
   endtask

   task automatic queue_upload();
      int plan;
      int last_req;
      int bad_seq;
      plan     = chance(8) ? $urandom_range(65535, 5) : $urandom_range(4, 1);
      last_req = (plan > 4) ? 3 : plan;
      add_msg(ACT_START_UPLOAD, rnd16(), 16'(plan), rnd8());
      for (int i = 0; i <= last_req; i++) begin
         add_ticks();
         maybe_busy();
         if (chance(14)) begin
            bad_seq = (plan >= 65534) ? 65535 : $urandom_range(65535, plan + 1);
            add_msg(ACT_REQUEST, 16'(bad_seq), rnd16(), rnd8());
         end else begin
            add_msg(ACT_REQUEST, 16'(i), rnd16(), rnd8());
            if (chance(10)) add_msg(ACT_REQUEST, 16'(i), rnd16(), rnd8());
         end
      end
      add_ticks();
      add_ack();
   endtask

   task automatic queue_download();
      int total;
      add_msg(ACT_START_DOWNLOAD, rnd16(), rnd16(), rnd8());
      // an item before the count meets a stale index
      if (chance(10)) add_msg(ACT_ITEM, 16'($urandom_range(3, 0)), rnd16(), rnd8());
      add_ticks();
      total = chance(8) ? 0 : $urandom_range(4, 1);
      add_msg(ACT_COUNT, rnd16(), 16'(total), rnd8());
      if (chance(10)) begin
         add_msg(ACT_ITEM, 16'd0, rnd16(), rnd8());
         total = $urandom_range(4, 1);
         add_msg(ACT_COUNT, rnd16(), 16'(total), rnd8());
      end
      for (int i = 0; i < total; i++) begin
         add_ticks();
         maybe_busy();
         if (chance(8)) add_msg(ACT_ITEM, 16'(i + $urandom_range(5, 1)), rnd16(), rnd8());
         if (chance(12)) add_ack();
         add_msg(ACT_ITEM, 16'(i), rnd16(), rnd8());
      end
   endtask

   task automatic queue_clear();
      add_msg(chance(3) ? ACT_START_UPLOAD : ACT_START_CLEAR, rnd16(), 16'd0, rnd8());
      add_ticks();
      maybe_busy();
      add_ack();
   endtask

   task automatic queue_random(int amount);
      int goal;
      int pick;
      goal = queued_count + amount;
      while (queued_count < goal) begin
         pick = $urandom_range(99, 0);
         if (pick < 35) queue_upload();
         else if (pick < 65) queue_download();
         else if (pick < 80) queue_clear();
         else repeat ($urandom_range(3, 1)) begin
            pending_msgs.push_back(any_msg());
            queued_count++;
         end
         // bring the engine back to idle whatever state the session left
         add_msg(ACT_ACK, rnd16(), rnd16(), 8'd0);
         add_msg(ACT_COUNT, rnd16(), 16'd0, rnd8());
      end
   endtask

   task automatic queue_directed();
      // messages in idle are dropped, a tick without timer does nothing
      add_msg(ACT_TICK, 0, 0, 0);
      add_msg(ACT_REQUEST, 0, 0, 0);
      add_msg(ACT_COUNT, 0, 3, 0);
      add_msg(ACT_ACK, 0, 0, 0);
      // full-size plan saturates the total, second start reports busy
      add_msg(ACT_START_UPLOAD, 0, 16'hFFFF, 0);
      add_msg(ACT_START_DOWNLOAD, 0, 0, 0);
      add_msg(ACT_REQUEST, 0, 0, 0);
      // one resend, then give up
      repeat (4) add_msg(ACT_TICK, 16'hFFFF, 16'hFFFF, 8'hFF);
      // download of two: ack ignored, out-of-order ignored, home not forwarded
      add_msg(ACT_START_DOWNLOAD, 0, 0, 0);
      add_msg(ACT_COUNT, 0, 2, 0);
      add_msg(ACT_ACK, 0, 0, 0);
      add_msg(ACT_ITEM, 1, 0, 0);
      add_msg(ACT_ITEM, 0, 0, 0);
      add_msg(ACT_ITEM, 1, 0, 0);
      pending_msgs[pending_msgs.size() - 1].in_command   = 16'hFFFF;
      pending_msgs[pending_msgs.size() - 1].in_latitude  = 32'sh8000_0000;
      pending_msgs[pending_msgs.size() - 1].in_longitude = 32'sh7FFF_FFFF;
      pending_msgs[pending_msgs.size() - 1].in_altitude  = 32'hFFFF_FFFF;
      // empty plan clears, rejected by the peer
      add_msg(ACT_START_UPLOAD, 0, 0, 0);
      add_msg(ACT_ACK, 0, 0, 8'hFF);
      add_msg(ACT_START_CLEAR, 0, 0, 0);
      add_msg(ACT_ACK, 0, 0, 0);
      // request past the end
      add_msg(ACT_START_UPLOAD, 0, 1, 0);
      add_msg(ACT_REQUEST, 2, 0, 0);
      // clean upload of one item
      add_msg(ACT_START_UPLOAD, 0, 1, 0);
      add_msg(ACT_REQUEST, 0, 0, 0);
      add_msg(ACT_REQUEST, 1, 0, 0);
      add_msg(ACT_ACK, 0, 0, 0);
   endtask

   // ---------------------------------------------------------------- sequencing

   task automatic apply_settings(logic [3:0] tries, logic [15:0] ticks, pace_type p);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_MAX_ATTEMPTS;
      csr_wdata    <= {12'd0, tries};
      @(posedge clock);
      csr_index    <= CSR_TIMEOUT_TICKS;
      csr_wdata    <= ticks;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_max_attempts = tries;
      cfg_timeout      = ticks;
      pace <= p;
      @(negedge clock);
   endtask

   // wait until every transaction is taken and every result is back
   task automatic drain();
      @(negedge clock);
      while (pending_msgs.size() != 0 || req_valid || pending_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic bit sender_idles();
      case (pace)
         PACE_SLOW_SINK:   return $urandom_range(99, 0) < 13;
         PACE_SLOW_SOURCE: return $urandom_range(99, 0) < 70;
         default:          return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (pace)
         PACE_SLOW_SINK:   return $urandom_range(99, 0) < 70;
         PACE_SLOW_SOURCE: return $urandom_range(99, 0) < 13;
         default:          return 1'b0;
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic note_field(string name, logic [31:0] seen, logic [31:0] want);
      if (seen !== want)
         report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                   results_seen, name, seen, want));
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_transfer(offer);
            accepted_count++;
         end
         // hold a stalled transaction, otherwise offer the next one or idle
         if (!req_valid || !req_stall) begin
            if (pending_msgs.size() != 0 && !sender_idles()) begin
               offer     <= pending_msgs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.send_kind      = rsp_send_kind;
            seen.send_number    = rsp_send_number;
            seen.event_code     = rsp_event_code;
            seen.progress_done  = rsp_progress_done;
            seen.progress_total = rsp_progress_total;
            seen.item_valid     = rsp_item_valid;
            seen.out_command    = rsp_out_command;
            seen.out_latitude   = rsp_out_latitude;
            seen.out_longitude  = rsp_out_longitude;
            seen.out_altitude   = rsp_out_altitude;
            seen.last_result    = rsp_last_result;
            results_seen++;
            if (!$isunknown(seen.event_code)) event_tally[seen.event_code]++;
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with none expected",
                                         results_seen));
            end else begin
               want = pending_results.pop_front();
               note_field("send_kind", 32'(seen.send_kind), 32'(want.send_kind));
               note_field("send_number", 32'(seen.send_number), 32'(want.send_number));
               note_field("event_code", 32'(seen.event_code), 32'(want.event_code));
               note_field("progress_done", 32'(seen.progress_done),
                          32'(want.progress_done));
               note_field("progress_total", 32'(seen.progress_total),
                          32'(want.progress_total));
               note_field("item_valid", 32'(seen.item_valid), 32'(want.item_valid));
               note_field("out_command", 32'(seen.out_command), 32'(want.out_command));
               note_field("out_latitude", 32'(seen.out_latitude),
                          32'(want.out_latitude));
               note_field("out_longitude", 32'(seen.out_longitude),
                          32'(want.out_longitude));
               note_field("out_altitude", 32'(seen.out_altitude),
                          32'(want.out_altitude));
               note_field("last_result", 32'(seen.last_result), 32'(want.last_result));
            end
         end
         // once, in the unpaced phase, hold off long enough to back up the input
         if (hold_left == 0 && !hold_used && pace == PACE_FREE && rsp_valid) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= receiver_stalls();
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- test flow

   initial begin
      foreach (event_tally[i]) event_tally[i] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      apply_settings(4'd2, 16'd2, PACE_SLOW_SINK);
      queue_directed();
      drain();

      apply_settings(4'd15, 16'hFFFF, PACE_SLOW_SINK);
      queue_random(50);
      drain();

      apply_settings(4'd0, 16'd0, PACE_SLOW_SOURCE);
      queue_random(50);
      drain();

      apply_settings(4'd1, 16'd1, PACE_SLOW_SOURCE);
      queue_random(50);
      drain();

      apply_settings(4'd5, 16'd4, PACE_FREE);
      queue_random(55);
      drain();

      $display("Checked %0d results from %0d transactions over five retry settings",
               results_seen, accepted_count);
      $display("Events: progress %0d, upload done %0d, download done %0d, cleared %0d,",
               event_tally[EV_PROGRESS], event_tally[EV_UPLOAD_DONE],
               event_tally[EV_DOWN_DONE], event_tally[EV_CLEARED]);
      $display("        busy %0d, no response %0d, bad index %0d, rejected %0d",
               event_tally[EV_BUSY], event_tally[EV_NO_RESPONSE],
               event_tally[EV_BAD_INDEX], event_tally[EV_REJECTED]);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/mth_pkg.sv
rtl/mission_transfer_handshake_unit.sv
test/tb_top.sv
